[sv/qcuv_pkg.sv]
// Shared types and constants for the quad clip / texture re-interpolation block.
// Holds register indexes, queue sizing and the queue status bundle.
// No dependencies.
package qcuv_pkg;

  localparam int CFG_AW = 3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_CROP_LEFT   = 3'd0,
    CFG_CROP_TOP    = 3'd1,
    CFG_CROP_RIGHT  = 3'd2,
    CFG_CROP_BOTTOM = 3'd3
  } cfg_reg_t;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int LVL_W      = 3;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             empty;
  } fifo_stat_t;

  // texture lanes handled side by side in one cut unit
  localparam int LANES = 4;

endpackage

[sv/qcuv_front.sv]
// Front part: crop registers, word intake and quad classification.
// Computes the crop intersection and visibility, hands one item per word to the queue.
// Depends on qcuv_pkg.
module qcuv_front
  import qcuv_pkg::*;
#(
  parameter int CW = 16,
  parameter int TW = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_AW-1:0]       cfg_addr,
  input  logic [CW-1:0]           cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [4*CW+8*TW-1:0]    in_data,
  input  fifo_stat_t              fstat,
  output logic                    push,
  output logic [8*CW+8*TW:0]      item
);

  localparam int RAW_W = 4*CW + 8*TW;
  localparam int IW    = 8*CW + 8*TW + 1;

  logic signed [CW-1:0] crop_l_r, crop_t_r, crop_r_r, crop_b_r;
  logic signed [CW-1:0] l, t, r, b, ix1, iy1, ix2, iy2;
  logic                 vis;
  logic [LVL_W:0]       occ;
  logic                 acc;
  logic                 valid_r;
  logic [IW-1:0]        item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_l_r <= {1'b1, {(CW-1){1'b0}}};
      crop_t_r <= {1'b1, {(CW-1){1'b0}}};
      crop_r_r <= {1'b0, {(CW-1){1'b1}}};
      crop_b_r <= {1'b0, {(CW-1){1'b1}}};
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CROP_LEFT:   crop_l_r <= cfg_wdata;
        CFG_CROP_TOP:    crop_t_r <= cfg_wdata;
        CFG_CROP_RIGHT:  crop_r_r <= cfg_wdata;
        CFG_CROP_BOTTOM: crop_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign l = in_data[0*CW +: CW];
  assign t = in_data[1*CW +: CW];
  assign r = in_data[2*CW +: CW];
  assign b = in_data[3*CW +: CW];

  assign ix1 = (l > crop_l_r) ? l : crop_l_r;
  assign ix2 = (r < crop_r_r) ? r : crop_r_r;
  assign iy1 = (t > crop_t_r) ? t : crop_t_r;
  assign iy2 = (b < crop_b_r) ? b : crop_b_r;
  assign vis = (ix1 < ix2) && (iy1 < iy2);

  // leave room in the queue for the word held here
  assign occ      = {1'b0, fstat.level} + {{LVL_W{1'b0}}, valid_r};
  assign in_ready = occ < (LVL_W+1)'(FIFO_DEPTH);
  assign acc      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= {vis, in_data[RAW_W-1:4*CW], iy2, ix2, iy1, ix1, in_data[4*CW-1:0]};
    end
  end

  assign push = valid_r;
  assign item = item_r;

endmodule

[sv/qcuv_fifo.sv]
// Short queue between front and back parts.
// Register based, one write and one read port, status as a struct.
// Depends on qcuv_pkg.
module qcuv_fifo
  import qcuv_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output fifo_stat_t   stat
);

  logic [W-1:0]       mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + LVL_W'(push) - LVL_W'(pop);
    end
  end

  assign rdata      = mem[rd_ptr_r];
  assign stat.level = cnt_r;
  assign stat.empty = (cnt_r == '0);

endmodule

[sv/qcuv_cut.sv]
// One edge cut for four texture lanes: base + trunc(diff * cut / span).
// Multiply stage, one restoring division step per stage, then sign fix and add.
// Depends on qcuv_pkg.
module qcuv_cut
  import qcuv_pkg::*;
#(
  parameter int CW = 16,
  parameter int TW = 16,
  parameter int SW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [LANES-1:0][TW-1:0]   base,
  input  logic [LANES-1:0][TW:0]     diff,
  input  logic [LANES-1:0][CW:0]     cut,
  input  logic [LANES-1:0][CW-1:0]   span,
  input  logic [SW-1:0]              side_i,
  output logic                       vld_o,
  output logic [LANES-1:0][TW-1:0]   res,
  output logic [SW-1:0]              side_o
);

  localparam int PW = TW + CW + 2;
  localparam int NW = TW + CW;

  // multiply stage
  logic                     vm_r;
  logic signed [PW-1:0]     prod_r [LANES];
  logic [CW-1:0]            span_m_r [LANES];
  logic [TW-1:0]            base_m_r [LANES];
  logic [SW-1:0]            side_m_r;

  // division steps
  logic [CW-1:0] rem_r  [TW][LANES];
  logic [TW-1:0] nlo_r  [TW][LANES];
  logic [TW-1:0] q_r    [TW][LANES];
  logic          neg_r  [TW][LANES];
  logic [CW-1:0] span_r [TW][LANES];
  logic [TW-1:0] base_r [TW][LANES];
  logic [SW-1:0] side_r [TW];
  logic          v_r    [TW];

  logic [CW-1:0] src_rem  [TW][LANES];
  logic [TW-1:0] src_nlo  [TW][LANES];
  logic [TW-1:0] src_q    [TW][LANES];
  logic [CW-1:0] src_span [TW][LANES];
  logic [CW-1:0] nxt_rem  [TW][LANES];
  logic [TW-1:0] nxt_nlo  [TW][LANES];
  logic [TW-1:0] nxt_q    [TW][LANES];
  logic          p_neg    [LANES];

  logic [LANES-1:0][TW-1:0] res_r;
  logic [SW-1:0]            side_o_r;
  logic                     vo_r;

  always_comb begin
    logic [PW-1:0] mag;
    logic [NW-1:0] magn;
    logic [CW:0]   tr;
    logic          ge;
    mag  = '0;
    magn = '0;
    tr   = '0;
    ge   = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      p_neg[l]       = prod_r[l][PW-1];
      mag            = p_neg[l] ? (~prod_r[l] + 1'b1) : prod_r[l];
      magn           = mag[NW-1:0];
      src_rem[0][l]  = magn[NW-1:TW];
      src_nlo[0][l]  = magn[TW-1:0];
      src_q[0][l]    = '0;
      src_span[0][l] = span_m_r[l];
    end
    for (int s = 1; s < TW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        src_rem[s][l]  = rem_r[s-1][l];
        src_nlo[s][l]  = nlo_r[s-1][l];
        src_q[s][l]    = q_r[s-1][l];
        src_span[s][l] = span_r[s-1][l];
      end
    end
    for (int s = 0; s < TW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        tr = {src_rem[s][l], src_nlo[s][l][TW-1]};
        ge = tr >= {1'b0, src_span[s][l]};
        if (ge) begin
          tr = tr - {1'b0, src_span[s][l]};
        end
        nxt_rem[s][l] = tr[CW-1:0];
        nxt_nlo[s][l] = {src_nlo[s][l][TW-2:0], 1'b0};
        nxt_q[s][l]   = {src_q[s][l][TW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      for (int s = 0; s < TW; s++) v_r[s] <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vm_r <= vld_i;
      v_r[0] <= vm_r;
      for (int s = 1; s < TW; s++) v_r[s] <= v_r[s-1];
      vo_r <= v_r[TW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        prod_r[l]   <= PW'($signed(diff[l])) * PW'($signed(cut[l]));
        span_m_r[l] <= span[l];
        base_m_r[l] <= base[l];
      end
      side_m_r <= side_i;
      for (int l = 0; l < LANES; l++) begin
        neg_r[0][l]  <= p_neg[l];
        base_r[0][l] <= base_m_r[l];
      end
      side_r[0] <= side_m_r;
      for (int s = 1; s < TW; s++) begin
        for (int l = 0; l < LANES; l++) begin
          neg_r[s][l]  <= neg_r[s-1][l];
          base_r[s][l] <= base_r[s-1][l];
        end
        side_r[s] <= side_r[s-1];
      end
      for (int s = 0; s < TW; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l]  <= nxt_rem[s][l];
          nlo_r[s][l]  <= nxt_nlo[s][l];
          q_r[s][l]    <= nxt_q[s][l];
          span_r[s][l] <= src_span[s][l];
        end
      end
      // apply the quotient with its sign, truncated toward zero
      for (int l = 0; l < LANES; l++) begin
        res_r[l] <= base_r[TW-1][l] +
                    (neg_r[TW-1][l] ? (~q_r[TW-1][l] + 1'b1) : q_r[TW-1][l]);
      end
      side_o_r <= side_r[TW-1];
    end
  end

  assign vld_o  = vo_r;
  assign res    = res_r;
  assign side_o = side_o_r;

endmodule

[sv/qcuv_back.sv]
// Back part: left/top cuts, then right/bottom cuts, then the output register.
// The whole pipeline advances while the output register is free or taken.
// Depends on qcuv_pkg and qcuv_cut.
module qcuv_back
  import qcuv_pkg::*;
#(
  parameter int CW = 16,
  parameter int TW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fifo_stat_t            fstat,
  input  logic [8*CW+8*TW:0]    fdata,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [4*CW+8*TW-1:0]  out_data,
  output logic                  out_vis
);

  localparam int IW  = 8*CW + 8*TW + 1;
  localparam int SW2 = IW + LANES*TW;

  // coordinate slots in an item
  localparam int C_L = 0, C_T = 1, C_R = 2, C_B = 3;
  localparam int C_IX1 = 4, C_IY1 = 5, C_IX2 = 6, C_IY2 = 7;
  // texture slots in an item
  localparam int T_AU0 = 0, T_AV0 = 1, T_AU1 = 2, T_AV1 = 3;
  localparam int T_BU0 = 4, T_BV0 = 5, T_BU1 = 6, T_BV1 = 7;
  // lanes
  localparam int LN_AU = 0, LN_BU = 1, LN_AV = 2, LN_BV = 3;

  function automatic logic [CW-1:0] crd(input logic [IW-1:0] it, input int k);
    crd = it[k*CW +: CW];
  endfunction

  function automatic logic [TW-1:0] txc(input logic [IW-1:0] it, input int k);
    txc = it[8*CW + k*TW +: TW];
  endfunction

  function automatic logic [CW:0] cdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    cdiff = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic [TW:0] tdiff(input logic [TW-1:0] a, input logic [TW-1:0] b);
    tdiff = {1'b0, a} - {1'b0, b};
  endfunction

  logic                     en;
  logic [LANES-1:0][TW-1:0] base1, base2, res1, res2, res1_d;
  logic [LANES-1:0][TW:0]   diff1, diff2;
  logic [LANES-1:0][CW:0]   cut1, cut2;
  logic [LANES-1:0][CW-1:0] span1, span2;
  logic [CW:0]              sx1, sy1, sx2, sy2;
  logic                     v1, v2;
  logic [IW-1:0]            it1, it2;
  logic [SW2-1:0]           side2_i, side2_o;

  logic                     out_valid_r;
  logic [4*CW+8*TW-1:0]     out_data_r;
  logic                     out_vis_r;

  // hold everything while a finished word waits
  assign en  = ~out_valid_r | out_ready;
  assign pop = en & ~fstat.empty;

  // left and top cuts
  assign sx1 = cdiff(crd(fdata, C_R), crd(fdata, C_L));
  assign sy1 = cdiff(crd(fdata, C_B), crd(fdata, C_T));

  always_comb begin
    base1[LN_AU] = txc(fdata, T_AU0);
    base1[LN_BU] = txc(fdata, T_BU0);
    base1[LN_AV] = txc(fdata, T_AV0);
    base1[LN_BV] = txc(fdata, T_BV0);
    diff1[LN_AU] = tdiff(txc(fdata, T_AU1), txc(fdata, T_AU0));
    diff1[LN_BU] = tdiff(txc(fdata, T_BU1), txc(fdata, T_BU0));
    diff1[LN_AV] = tdiff(txc(fdata, T_AV1), txc(fdata, T_AV0));
    diff1[LN_BV] = tdiff(txc(fdata, T_BV1), txc(fdata, T_BV0));
    cut1[LN_AU]  = cdiff(crd(fdata, C_IX1), crd(fdata, C_L));
    cut1[LN_BU]  = cut1[LN_AU];
    cut1[LN_AV]  = cdiff(crd(fdata, C_IY1), crd(fdata, C_T));
    cut1[LN_BV]  = cut1[LN_AV];
    span1[LN_AU] = sx1[CW-1:0];
    span1[LN_BU] = sx1[CW-1:0];
    span1[LN_AV] = sy1[CW-1:0];
    span1[LN_BV] = sy1[CW-1:0];
  end

  qcuv_cut #(.CW(CW), .TW(TW), .SW(IW)) u_cut1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (pop),
    .base   (base1),
    .diff   (diff1),
    .cut    (cut1),
    .span   (span1),
    .side_i (fdata),
    .vld_o  (v1),
    .res    (res1),
    .side_o (it1)
  );

  // right and bottom cuts use the updated start values and left/top edges
  assign sx2 = cdiff(crd(it1, C_R), crd(it1, C_IX1));
  assign sy2 = cdiff(crd(it1, C_B), crd(it1, C_IY1));

  always_comb begin
    base2[LN_AU] = txc(it1, T_AU1);
    base2[LN_BU] = txc(it1, T_BU1);
    base2[LN_AV] = txc(it1, T_AV1);
    base2[LN_BV] = txc(it1, T_BV1);
    diff2[LN_AU] = tdiff(txc(it1, T_AU1), res1[LN_AU]);
    diff2[LN_BU] = tdiff(txc(it1, T_BU1), res1[LN_BU]);
    diff2[LN_AV] = tdiff(txc(it1, T_AV1), res1[LN_AV]);
    diff2[LN_BV] = tdiff(txc(it1, T_BV1), res1[LN_BV]);
    cut2[LN_AU]  = cdiff(crd(it1, C_IX2), crd(it1, C_R));
    cut2[LN_BU]  = cut2[LN_AU];
    cut2[LN_AV]  = cdiff(crd(it1, C_IY2), crd(it1, C_B));
    cut2[LN_BV]  = cut2[LN_AV];
    span2[LN_AU] = sx2[CW-1:0];
    span2[LN_BU] = sx2[CW-1:0];
    span2[LN_AV] = sy2[CW-1:0];
    span2[LN_BV] = sy2[CW-1:0];
  end

  assign side2_i = {res1, it1};

  qcuv_cut #(.CW(CW), .TW(TW), .SW(SW2)) u_cut2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v1),
    .base   (base2),
    .diff   (diff2),
    .cut    (cut2),
    .span   (span2),
    .side_i (side2_i),
    .vld_o  (v2),
    .res    (res2),
    .side_o (side2_o)
  );

  assign it2    = side2_o[IW-1:0];
  assign res1_d = side2_o[SW2-1:IW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vis_r <= it2[IW-1];
      if (it2[IW-1]) begin
        out_data_r <= {res2[LN_BV], res2[LN_BU], res1_d[LN_BV], res1_d[LN_BU],
                       res2[LN_AV], res2[LN_AU], res1_d[LN_AV], res1_d[LN_AU],
                       crd(it2, C_IY2), crd(it2, C_IX2), crd(it2, C_IY1), crd(it2, C_IX1)};
      end else begin
        out_data_r <= {it2[IW-2:8*CW], it2[4*CW-1:0]};
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_vis   = out_vis_r;

endmodule

[sv/quad_clip_uv_interpolate_top.sv]
// Quad clipper with texture re-interpolation: one word per cycle sustained while the sink takes
// results (out_tready low holds the back pipeline and then the input), set by the fully pipelined
// cut units (one multiply stage, TEX_WIDTH division steps and one add stage each, two in series).
// Reset (rst_n low, synchronous) empties the queue and pipeline and loads the crop rectangle
// to the full coordinate range.
module quad_clip_uv_interpolate_top
  import qcuv_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int TEX_WIDTH   = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: index 0 crop_left, 1 crop_top, 2 crop_right, 3 crop_bottom
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [COORD_WIDTH-1:0] cfg_wdata,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // left_x, top_y, right_x, bottom_y, tex_a_start, tex_a_end, tex_b_start, tex_b_end
  input  logic [((4*COORD_WIDTH+8*TEX_WIDTH+7)/8)*8-1:0] in_tdata,
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_left_x, out_top_y, out_right_x, out_bottom_y,
  // out_tex_a_start, out_tex_a_end, out_tex_b_start, out_tex_b_end
  output logic [((4*COORD_WIDTH+8*TEX_WIDTH+7)/8)*8-1:0] out_tdata,
  // visible
  output logic [0:0]            out_tuser
);

  localparam int RAW_W = 4*COORD_WIDTH + 8*TEX_WIDTH;
  localparam int BUS_W = ((RAW_W + 7) / 8) * 8;
  localparam int IW    = 8*COORD_WIDTH + 8*TEX_WIDTH + 1;

  fifo_stat_t        fstat;
  logic              push, pop;
  logic [IW-1:0]     item, fdata;
  logic [RAW_W-1:0]  od;
  logic              vis;

  // front: crop registers, intersection and visibility, one word in per cycle while the queue has room
  qcuv_front #(.CW(COORD_WIDTH), .TW(TEX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata[RAW_W-1:0]),
    .fstat     (fstat),
    .push      (push),
    .item      (item)
  );

  // queue: lets the front keep taking words while the back is held by the sink
  qcuv_fifo #(.W(IW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item),
    .pop   (pop),
    .rdata (fdata),
    .stat  (fstat)
  );

  // back: two cut pipelines and the output register
  qcuv_back #(.CW(COORD_WIDTH), .TW(TEX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fstat     (fstat),
    .fdata     (fdata),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (od),
    .out_vis   (vis)
  );

  // pad to whole bytes with zeros
  assign out_tdata    = BUS_W'(od);
  assign out_tuser[0] = vis;

endmodule
